[design/mfs_pkg.sv]
`timescale 1ns / 1ps
package mfs_pkg;

  // Fixed width of the value field on both channels.
  localparam int VALUE_W  = 10;
  localparam int STATUS_W = 2;

  // Command codes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic               command;
    logic [VALUE_W-1:0] value;
  } mfs_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  popped_value;
  } mfs_out_t;

endpackage

[design/mfs_ram.sv]
`timescale 1ns / 1ps
module mfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/mfs_mod.sv]
`timescale 1ns / 1ps
module mfs_mod #(
  parameter int VALUE_RANGE = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [mfs_pkg::VALUE_W-1:0]    din,
  output logic                           done,
  output logic [$clog2(VALUE_RANGE)-1:0] dout
);

  localparam int NW    = mfs_pkg::VALUE_W;
  localparam int VW    = $clog2(VALUE_RANGE);
  localparam int RW    = NW + 2;
  localparam int PW    = NW + RW;
  localparam int SHIFT = NW + VW;
  // Rounded-up reciprocal of the range; exact quotients for every NW-bit value.
  localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(VALUE_RANGE) - 1)
                               / longint'(VALUE_RANGE);
  localparam logic [RW-1:0] RECIP  = RW'(RECIP_L);
  // The quotient times the range never exceeds the value, so NW bits suffice.
  localparam logic [NW-1:0] DIV_LO = NW'(VALUE_RANGE);

  logic              v1_r, v2_r, done_r;
  logic [NW-1:0]     din_r;
  logic [NW-1:0]     q_r, q_nxt;
  logic [NW-1:0]     rem_r, rem_nxt;
  logic [PW-1:0]     prod;
  logic [NW+VW-1:0]  out_ext;

  // Quotient by reciprocal multiplication, then remainder by one subtraction.
  assign prod    = PW'(din_r) * PW'(RECIP);
  assign q_nxt   = NW'(prod >> SHIFT);
  assign rem_nxt = din_r - q_r * DIV_LO;

  // Three-stage pipeline: capture, quotient, remainder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
    if (start) begin
      din_r <= din;
    end
    if (v1_r) begin
      q_r <= q_nxt;
    end
    if (v2_r) begin
      rem_r <= rem_nxt;
    end
  end

  // The remainder is below the range, so the resize keeps every set bit.
  assign out_ext = {{VW{1'b0}}, rem_r};
  assign dout    = out_ext[VW-1:0];
  assign done    = done_r;

endmodule

[design/max_frequency_stack.sv]
`timescale 1ns / 1ps
// Maximum-frequency stack: one transaction at a time, in_stall high while busy.
// Push: three-stage value reduction, then count update; a full push or an empty pop
// goes straight to the response. Pop: the slot memory read port scans every slot
// and then moves the later slots down. Input reopens in the same cycle as each result.
// Reset (synchronous, active low) empties the stack, then clears every count entry.
module max_frequency_stack #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_RANGE = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mfs_pkg::mfs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mfs_pkg::mfs_out_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int CW = FW;
  localparam int VW = $clog2(VALUE_RANGE);
  localparam int SW = VW + CW;
  localparam int PW = mfs_pkg::VALUE_W + VW;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PUSH_RD,
    S_PUSH_WR,
    S_SCAN,
    S_SHIFT,
    S_POP_RD,
    S_POP_WR,
    S_RESP
  } state_t;

  state_t            state_r, state_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [VW-1:0]     clr_r, clr_nxt;
  logic [VW-1:0]     key_r, key_nxt;
  logic [FW-1:0]     issue_r, issue_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]     best_r, best_nxt;
  logic [CW-1:0]     best_cnt_r, best_cnt_nxt;
  logic [VW-1:0]     best_val_r, best_val_nxt;
  mfs_pkg::mfs_out_t res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  mfs_pkg::mfs_out_t out_data_r, out_data_nxt;

  // Memory port signals.
  logic          slot_we, slot_re;
  logic [AW-1:0] slot_waddr, slot_raddr;
  logic [SW-1:0] slot_wdata, slot_rdata;
  logic          cnt_we, cnt_re;
  logic [VW-1:0] cnt_waddr, cnt_raddr;
  logic [CW-1:0] cnt_wdata, cnt_rdata;

  logic          mod_start, mod_done;
  logic [VW-1:0] mod_dout;

  logic [CW-1:0] rd_cnt;
  logic [VW-1:0] rd_val;
  logic [PW-1:0] pop_ext;
  logic          accept;

  assign rd_cnt = slot_rdata[CW-1:0];
  assign rd_val = slot_rdata[SW-1:CW];
  assign accept = in_valid && !in_stall;
  assign pop_ext = {{mfs_pkg::VALUE_W{1'b0}}, best_val_r};

  // Handshake outputs.
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mfs_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  mfs_ram #(.WIDTH(CW), .DEPTH(VALUE_RANGE)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  mfs_mod #(.VALUE_RANGE(VALUE_RANGE)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .din   (in_data.value),
    .done  (mod_done),
    .dout  (mod_dout)
  );

  // Sequencer for push, pop scan, compaction and count update.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    clr_nxt       = clr_r;
    key_nxt       = key_r;
    issue_nxt     = issue_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    best_nxt      = best_r;
    best_cnt_nxt  = best_cnt_r;
    best_val_nxt  = best_val_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cnt_we        = 1'b0;
    cnt_waddr     = key_r;
    cnt_wdata     = cnt_rdata + CW'(1);
    cnt_re        = 1'b0;
    cnt_raddr     = key_r;
    slot_we       = 1'b0;
    slot_waddr    = fill_r[AW-1:0];
    slot_wdata    = {key_r, cnt_wdata};
    slot_re       = 1'b0;
    slot_raddr    = issue_r[AW-1:0];
    mod_start     = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
        clr_nxt   = clr_r + VW'(1);
        if (clr_r == VW'(VALUE_RANGE - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          res_nxt.popped_value = '0;
          res_nxt.status       = mfs_pkg::ST_OK;
          if (in_data.command == mfs_pkg::CMD_PUSH) begin
            if (fill_r == FW'(CAPACITY)) begin
              res_nxt.status = mfs_pkg::ST_FULL;
              state_nxt      = S_RESP;
            end else begin
              mod_start = 1'b1;
              state_nxt = S_MOD;
            end
          end else begin
            if (fill_r == '0) begin
              res_nxt.status = mfs_pkg::ST_EMPTY;
              state_nxt      = S_RESP;
            end else begin
              issue_nxt = '0;
              state_nxt = S_SCAN;
            end
          end
        end
      end

      S_MOD: begin
        if (mod_done) begin
          key_nxt   = mod_dout;
          state_nxt = S_PUSH_RD;
        end
      end

      S_PUSH_RD: begin
        cnt_re    = 1'b1;
        state_nxt = S_PUSH_WR;
      end

      S_PUSH_WR: begin
        cnt_we    = 1'b1;
        slot_we   = 1'b1;
        fill_nxt  = fill_r + FW'(1);
        state_nxt = S_RESP;
      end

      S_SCAN: begin
        if (issue_r < fill_r) begin
          slot_re    = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = issue_r[AW-1:0];
          issue_nxt  = issue_r + FW'(1);
        end
        // Later slots win ties, so a count equal to the best takes over.
        if (rd_vld_r) begin
          if (rd_idx_r == '0 || rd_cnt >= best_cnt_r) begin
            best_nxt     = rd_idx_r;
            best_cnt_nxt = rd_cnt;
            best_val_nxt = rd_val;
          end
        end
        if (issue_r == fill_r && !rd_vld_r) begin
          issue_nxt = FW'(best_r) + FW'(1);
          state_nxt = S_SHIFT;
        end
      end

      S_SHIFT: begin
        if (issue_r < fill_r) begin
          slot_re    = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = issue_r[AW-1:0];
          issue_nxt  = issue_r + FW'(1);
        end
        // Each slot read in the previous cycle moves down one place.
        if (rd_vld_r) begin
          slot_we    = 1'b1;
          slot_waddr = rd_idx_r - AW'(1);
          slot_wdata = slot_rdata;
        end
        if (issue_r == fill_r && !rd_vld_r) begin
          fill_nxt  = fill_r - FW'(1);
          key_nxt   = best_val_r;
          state_nxt = S_POP_RD;
        end
      end

      S_POP_RD: begin
        cnt_re    = 1'b1;
        state_nxt = S_POP_WR;
      end

      S_POP_WR: begin
        cnt_we    = (cnt_rdata != '0);
        cnt_wdata = cnt_rdata - CW'(1);
        res_nxt.popped_value = pop_ext[mfs_pkg::VALUE_W-1:0];
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      fill_r      <= '0;
      clr_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      clr_r       <= clr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r      <= key_nxt;
    issue_r    <= issue_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_r     <= best_nxt;
    best_cnt_r <= best_cnt_nxt;
    best_val_r <= best_val_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[sim/max_frequency_stack_test.sv]
`timescale 1ns / 1ps
module max_frequency_stack_test;

  localparam int VALUE_W     = mfs_pkg::VALUE_W;
  localparam int CAPACITY    = 256;
  localparam int VALUE_RANGE = 1024;
  localparam int COUNT_W     = 9;
  // Transactions queued before the final drain of the stack.
  localparam int RANDOM_END  = 460;
  // The receiver holds off once, after this many replies.
  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 2500;
  localparam int SETTLE_CYCLES = 600;
  localparam int CYCLE_LIMIT   = 2000000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  mfs_pkg::mfs_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  mfs_pkg::mfs_out_t out_data;

  // Stimulus waiting to be offered and replies waiting to be seen.
  mfs_pkg::mfs_in_t  pending_ops[$];
  mfs_pkg::mfs_out_t expected_replies[$];

  // Local copy of the stack, updated as each transaction is accepted.
  logic [VALUE_W-1:0] slot_val[CAPACITY];
  logic [COUNT_W-1:0] slot_cnt[CAPACITY];
  logic [COUNT_W-1:0] copies[VALUE_RANGE] = '{default: '0};
  int                 stack_fill = 0;

  int  gen_fill = 0;
  int  total_ops = 0;
  int  ops_accepted = 0;
  int  replies_seen = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  send_wait = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  send_calm = 1'b0;
  bit  recv_calm = 1'b0;

  max_frequency_stack #(
    .CAPACITY   (CAPACITY),
    .VALUE_RANGE(VALUE_RANGE)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    return VALUE_W'($urandom_range(0, VALUE_RANGE - 1));
  endfunction

  // Apply one accepted transaction to the local stack and queue its reply.
  task automatic predict_stack_op(input mfs_pkg::mfs_in_t txn);
    mfs_pkg::mfs_out_t reply;
    int                best;
    int                v;
    reply.status       = mfs_pkg::ST_OK;
    reply.popped_value = '0;
    if (txn.command == mfs_pkg::CMD_PUSH) begin
      if (stack_fill >= CAPACITY) begin
        reply.status = mfs_pkg::ST_FULL;
      end else begin
        v = txn.value % VALUE_RANGE;
        copies[v] = copies[v] + 1'b1;
        slot_val[stack_fill] = VALUE_W'(v);
        slot_cnt[stack_fill] = copies[v];
        stack_fill++;
      end
    end else if (stack_fill == 0) begin
      reply.status = mfs_pkg::ST_EMPTY;
    end else begin
      // Highest count wins; on a tie the later slot wins.
      best = 0;
      for (int i = 1; i < stack_fill; i++) begin
        if (slot_cnt[i] >= slot_cnt[best]) best = i;
      end
      reply.popped_value = slot_val[best];
      for (int i = best; i + 1 < stack_fill; i++) begin
        slot_val[i] = slot_val[i + 1];
        slot_cnt[i] = slot_cnt[i + 1];
      end
      stack_fill--;
      v = reply.popped_value % VALUE_RANGE;
      if (copies[v] > 0) copies[v] = copies[v] - 1'b1;
    end
    expected_replies.push_back(reply);
  endtask

  task automatic check_reply(input mfs_pkg::mfs_out_t got);
    mfs_pkg::mfs_out_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch($sformatf("unexpected reply status %0d value %0d",
                                got.status, got.popped_value));
      return;
    end
    want = expected_replies.pop_front();
    if (got.status !== want.status) begin
      report_mismatch($sformatf("reply %0d status %0d, expected %0d",
                                replies_seen, got.status, want.status));
    end
    if (got.popped_value !== want.popped_value) begin
      report_mismatch($sformatf("reply %0d popped_value %0d, expected %0d",
                                replies_seen, got.popped_value, want.popped_value));
    end
  endtask

  // Queue one transaction and track how full the stack will be.
  task automatic queue_op(input logic cmd, input logic [VALUE_W-1:0] value);
    mfs_pkg::mfs_in_t op;
    op.command = cmd;
    op.value   = value;
    pending_ops.push_back(op);
    if (cmd == mfs_pkg::CMD_PUSH) begin
      if (gen_fill < CAPACITY) gen_fill++;
    end else if (gen_fill > 0) begin
      gen_fill--;
    end
  endtask

  // Driver: offers the next transaction after a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_stack_op(in_data);
        ops_accepted++;
        send_wait = send_calm ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
      end
      if (!(in_valid && in_stall)) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_ops.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each reply, then stalls for a random number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_reply(out_data);
        replies_seen++;
        if (replies_seen == HOLD_AT) begin
          hold_left = HOLD_CYCLES;
        end else begin
          stall_left = recv_calm ? 0 : $urandom_range(0, 14);
        end
        if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d replies outstanding", expected_replies.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [VALUE_W-1:0] pool[4];
    int                 segment;
    int                 seg_kind;
    int                 seg_len;
    int                 push_pct;

    // Directed part: empty pop, field extremes, count ties and recency.
    queue_op(mfs_pkg::CMD_POP, 10'h3FF);
    queue_op(mfs_pkg::CMD_PUSH, 10'd0);
    queue_op(mfs_pkg::CMD_PUSH, 10'd1023);
    queue_op(mfs_pkg::CMD_PUSH, 10'd1023);
    queue_op(mfs_pkg::CMD_PUSH, 10'd0);
    queue_op(mfs_pkg::CMD_PUSH, 10'd512);
    queue_op(mfs_pkg::CMD_PUSH, 10'h155);
    queue_op(mfs_pkg::CMD_PUSH, 10'h2AA);
    queue_op(mfs_pkg::CMD_PUSH, 10'd1023);
    repeat (8) queue_op(mfs_pkg::CMD_POP, 10'h000);
    queue_op(mfs_pkg::CMD_POP, 10'h2AA);

    // Random part: segments of pushes and pops, with pushes mostly drawn from small value pools,
    // with one segment that fills the stack and pushes past full.
    segment = 0;
    while (pending_ops.size() < RANDOM_END) begin
      foreach (pool[k]) pool[k] = rand_value();
      if (segment == 4) begin
        while (gen_fill < CAPACITY) begin
          queue_op(mfs_pkg::CMD_PUSH, pool[2'($urandom_range(0, 3))]);
        end
        repeat (3) queue_op(mfs_pkg::CMD_PUSH, rand_value());
      end else begin
        seg_kind = $urandom_range(0, 3);
        seg_len  = $urandom_range(4, 30);
        case (seg_kind)
          0: push_pct = 80;
          1: push_pct = 25;
          default: push_pct = 55;
        endcase
        repeat (seg_len) begin
          if ($urandom_range(0, 99) < push_pct) begin
            if (seg_kind == 2) queue_op(mfs_pkg::CMD_PUSH, rand_value());
            else queue_op(mfs_pkg::CMD_PUSH, pool[2'($urandom_range(0, 3))]);
          end else begin
            queue_op(mfs_pkg::CMD_POP, rand_value());
          end
        end
      end
      segment++;
    end

    // Drain the stack and pop once more while empty.
    while (gen_fill > 0) queue_op(mfs_pkg::CMD_POP, rand_value());
    queue_op(mfs_pkg::CMD_POP, rand_value());
    total_ops = pending_ops.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (ops_accepted == total_ops && expected_replies.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
